@@ rtl/sbpg_pkg.sv @@
// Shared constants and field widths for the spectrum bar pixel generator.
package sbpg_pkg;

  // Defaults for the top-level parameters
  localparam int BAR_COUNT_DEF    = 16;
  localparam int PANEL_WIDTH_DEF  = 64;
  localparam int PANEL_HEIGHT_DEF = 64;

  // Fixed port field widths
  localparam int IDX_W   = 4;
  localparam int FRAC_W  = 17;
  localparam int COORD_W = 6;
  localparam int COLOR_W = 8;

  // Q1.16 full scale and rounding half LSB
  localparam logic [FRAC_W-1:0] FULL_SCALE = 17'h10000;
  localparam int                HALF_LSB   = 32768;
  localparam int                FRAC_SHIFT = 16;

  // Request codes
  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'hFF;
  localparam logic [COLOR_W-1:0] COLOR_OFF = 8'h00;

endpackage

@@ rtl/sbpg_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module sbpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/spectrum_bar_pixel_generator.sv @@
// Spectrum analyzer bar graph pixel generator: bar/peak store and pixel colorizer.
//
// Usage: drive an item with start high. busy is always low, so one item may
// be given every cycle.
//   req_type = update: bar_index, level_frac and peak_frac (Q1.16, saturated
//     at 1.0) are turned into pixel heights and written to the bar store in
//     the cycle the item is taken. No result is produced.
//   req_type = query: pixel_x/pixel_y select one panel pixel. Its color shows
//     on red/green/blue with strobe high for one cycle, once the bar store read
//     and the color logic have each been registered.
// Throughput: one item per cycle. The bar store has one write and one read
// port and a write lands before any later query reads it, so an update
// followed directly by a query of the same bar returns the new heights.
// Reset: clears the pipeline and the per-bar valid bits; a bar never written
// since reset reads as zero height, so the panel is blank.
// The receiver cannot stall: a result is shown for exactly one cycle.
module spectrum_bar_pixel_generator #(
  parameter int BAR_COUNT    = sbpg_pkg::BAR_COUNT_DEF,
  parameter int PANEL_WIDTH  = sbpg_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = sbpg_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [sbpg_pkg::IDX_W-1:0]    bar_index,
  input  logic [sbpg_pkg::FRAC_W-1:0]   level_frac,
  input  logic [sbpg_pkg::FRAC_W-1:0]   peak_frac,
  input  logic [sbpg_pkg::COORD_W-1:0]  pixel_x,
  input  logic [sbpg_pkg::COORD_W-1:0]  pixel_y,
  output logic                          strobe,
  output logic [sbpg_pkg::COLOR_W-1:0]  red,
  output logic [sbpg_pkg::COLOR_W-1:0]  green,
  output logic [sbpg_pkg::COLOR_W-1:0]  blue
);

  import sbpg_pkg::*;

  localparam int AW    = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
  localparam int HW    = $clog2(PANEL_HEIGHT + 1);
  localparam int YW    = $clog2(PANEL_HEIGHT);
  localparam int MW    = FRAC_W + $clog2(PANEL_HEIGHT + 1) + 1;
  localparam int TOP   = PANEL_HEIGHT - 1;
  localparam int BW    = PANEL_WIDTH / BAR_COUNT;
  localparam int BWD   = (BW == 0) ? 1 : BW;
  localparam int XN    = 2 ** COORD_W;
  localparam int CMP_W = 10;

  // ---------------- constant tables ----------------
  logic [AW-1:0]      col_bar [XN];
  logic [XN-1:0]      col_on;
  logic [COLOR_W-1:0] grad_lut [PANEL_HEIGHT];

  for (genvar gx = 0; gx < XN; gx++) begin : g_col
    localparam int BarNo  = gx / BWD;
    localparam int Within = gx % BWD;
    localparam bit On = (gx < PANEL_WIDTH) && (BW != 0) && (BarNo < BAR_COUNT) &&
                        (Within != BW - 1);
    assign col_bar[gx] = AW'(BarNo);
    assign col_on[gx]  = On;
  end

  for (genvar gy = 0; gy < PANEL_HEIGHT; gy++) begin : g_grad
    assign grad_lut[gy] = COLOR_W'((510 * gy) / TOP);
  end

  // ---------------- stage 0: transfer, height conversion, store access ----------------
  logic              xfer;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [FRAC_W-1:0] level_sat;
  logic [FRAC_W-1:0] peak_sat;
  logic [MW-1:0]     level_prod;
  logic [MW-1:0]     peak_prod;
  logic [HW-1:0]     level_h;
  logic [HW-1:0]     peak_h;
  logic [AW-1:0]     rd_addr;
  logic              y_ok;
  logic [2*HW-1:0]   rd_data;
  logic [BAR_COUNT-1:0] ent_valid;

  assign busy = 1'b0;
  assign xfer = start && !busy;

  assign level_sat  = (level_frac > FULL_SCALE) ? FULL_SCALE : level_frac;
  assign peak_sat   = (peak_frac > FULL_SCALE) ? FULL_SCALE : peak_frac;
  assign level_prod = MW'(level_sat) * MW'(PANEL_HEIGHT) + MW'(HALF_LSB);
  assign peak_prod  = MW'(peak_sat) * MW'(PANEL_HEIGHT) + MW'(HALF_LSB);
  assign level_h    = HW'(level_prod >> FRAC_SHIFT);
  assign peak_h     = HW'(peak_prod >> FRAC_SHIFT);

  assign wr_en   = xfer && (req_type == REQ_UPDATE) &&
                   (CMP_W'(bar_index) < CMP_W'(BAR_COUNT));
  assign wr_addr = AW'(bar_index);
  assign rd_addr = col_bar[pixel_x];
  assign y_ok    = CMP_W'(pixel_y) < CMP_W'(PANEL_HEIGHT);

  sbpg_ram #(
    .WIDTH (2 * HW),
    .DEPTH (BAR_COUNT),
    .AW    (AW)
  ) u_bar_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({level_h, peak_h}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Valid bits stand in for clearing the store at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[wr_addr] <= 1'b1;
    end
  end

  // ---------------- stage 1 registers ----------------
  logic          s1_valid;
  logic          s1_draw;
  logic          s1_ent_ok;
  logic [YW-1:0] s1_yy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= xfer && (req_type == REQ_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    s1_draw   <= col_on[pixel_x] && y_ok;
    s1_ent_ok <= ent_valid[rd_addr];
    s1_yy     <= YW'(TOP) - YW'(pixel_y);
  end

  // ---------------- stage 1: color ----------------
  logic [HW-1:0]      bar_h;
  logic [HW-1:0]      pk_h;
  logic [YW-1:0]      peak_row;
  logic               upper;
  logic [YW-1:0]      grad_idx;
  logic [COLOR_W-1:0] grad_val;
  logic [COLOR_W-1:0] red_next;
  logic [COLOR_W-1:0] green_next;
  logic [COLOR_W-1:0] blue_next;

  assign bar_h    = s1_ent_ok ? rd_data[2*HW-1:HW] : '0;
  assign pk_h     = s1_ent_ok ? rd_data[HW-1:0] : '0;
  assign peak_row = (pk_h >= HW'(TOP)) ? YW'(TOP) : YW'(pk_h);
  // Lower half ramps red up, upper half ramps green down
  assign upper    = (CMP_W'(s1_yy) << 1) >= CMP_W'(TOP);
  assign grad_idx = upper ? (YW'(TOP) - s1_yy) : s1_yy;
  assign grad_val = grad_lut[grad_idx];

  always_comb begin
    red_next   = COLOR_OFF;
    green_next = COLOR_OFF;
    blue_next  = COLOR_OFF;
    if (s1_draw) begin
      if ((pk_h != '0) && (s1_yy == peak_row)) begin
        red_next   = COLOR_MAX;
        green_next = COLOR_MAX;
        blue_next  = COLOR_MAX;
      end else if (HW'(s1_yy) < bar_h) begin
        red_next   = upper ? COLOR_MAX : grad_val;
        green_next = upper ? grad_val : COLOR_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule

@@ rtl/sbpg_checker.sv @@
// Port-level checker for the spectrum bar pixel generator, bound to the top level.
module sbpg_port_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          req_type,
  input logic                          strobe,
  input logic [sbpg_pkg::COLOR_W-1:0]  red,
  input logic [sbpg_pkg::COLOR_W-1:0]  green,
  input logic [sbpg_pkg::COLOR_W-1:0]  blue
);

  import sbpg_pkg::*;

  // Every query transfer yields a result
  a_query_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_QUERY) |-> ##2 strobe)
    else $error("query transfer without result");

  // No result without an earlier query transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy && req_type == REQ_QUERY, 2))
    else $error("result without query");

  // Reset clears the output strobe
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("strobe after reset");

  // Blue only appears in the white peak row
  a_blue_white: assert property (@(posedge clk) disable iff (rst)
    (strobe && blue != COLOR_OFF) |->
      (red == COLOR_MAX && green == COLOR_MAX && blue == COLOR_MAX))
    else $error("blue outside peak row");

endmodule

bind spectrum_bar_pixel_generator sbpg_port_checker u_sbpg_checker (.*);
